>>> sv/pcc_pkg.sv
// ----------------------------------------------------------------------------
// pcc_pkg
// Widths, constants, rotation tables and item types of the polar/cartesian
// converter.
// ----------------------------------------------------------------------------
package pcc_pkg;

   localparam int COORD_WIDTH         = 24;
   localparam int ANGLE_FRACTION_BITS = 20;
   localparam int CORDIC_STAGES       = 20;

   localparam int COORD_GUARD = 4;
   localparam int ANGLE_GUARD = 4;

   localparam int RADIUS_W    = COORD_WIDTH - 1;
   localparam int ANGLE_IN_W  = ANGLE_FRACTION_BITS + 4;
   localparam int ANGLE_OUT_W = ANGLE_FRACTION_BITS + 3;

   // working formats inside the cell chain
   localparam int WORK_ANGLE_BITS = ANGLE_FRACTION_BITS + ANGLE_GUARD;
   localparam int WORK_COORD_W    = COORD_WIDTH + COORD_GUARD + 3;
   localparam int ZW              = WORK_ANGLE_BITS + 4;
   localparam int STAGE_IDX_W     = $clog2(CORDIC_STAGES);

   // gain multiply
   localparam int GAIN_W    = 31;
   localparam int GAIN_FRAC = 31;
   localparam int MAG_W     = WORK_COORD_W - 1;
   localparam int PROD_W    = MAG_W + GAIN_W;

   localparam int COORD_MAX = 2 ** (COORD_WIDTH - 1) - 1;
   localparam int COORD_MIN = -COORD_MAX - 1;

   // stream packing
   localparam int REQ_RADIUS_LSB = 0;
   localparam int REQ_ANGLE_LSB  = REQ_RADIUS_LSB + RADIUS_W;
   localparam int REQ_X_LSB      = REQ_ANGLE_LSB + ANGLE_IN_W;
   localparam int REQ_Y_LSB      = REQ_X_LSB + COORD_WIDTH;
   localparam int REQ_FIELDS_W   = REQ_Y_LSB + COORD_WIDTH;
   localparam int REQ_DATA_W     = ((REQ_FIELDS_W + 7) / 8) * 8;

   localparam int RSP_X_LSB      = 0;
   localparam int RSP_Y_LSB      = RSP_X_LSB + COORD_WIDTH;
   localparam int RSP_RADIUS_LSB = RSP_Y_LSB + COORD_WIDTH;
   localparam int RSP_ANGLE_LSB  = RSP_RADIUS_LSB + RADIUS_W;
   localparam int RSP_FIELDS_W   = RSP_ANGLE_LSB + ANGLE_OUT_W;
   localparam int RSP_DATA_W     = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam int OPCODE_TO_CARTESIAN = 0;
   localparam int OPCODE_TO_POLAR     = 1;

   // pi in Q60
   localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

   function automatic logic [63:0] pi_at(input int fb);
      return (PI_Q60 + (64'd1 << (59 - fb))) >> (60 - fb);
   endfunction

   // shift-subtract division, elaboration only
   function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [63:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // atan(2^-i) from a truncated taylor series in Q62, rounded to the working format
   function automatic logic [63:0] atan_step(input int i);
      logic [63:0] q;
      logic [63:0] term;
      q = '0;
      if (i == 0) begin
         q = PI_Q60;
      end else begin
         for (int k = 0; k < 32; k++) begin
            if (i * (2 * k + 1) <= 62) begin
               term = long_div(64'd1 << (62 - i * (2 * k + 1)), 64'(2 * k + 1));
               if (k % 2 == 1) begin
                  q = q - term;
               end else begin
                  q = q + term;
               end
            end
         end
      end
      return (q + (64'd1 << (61 - WORK_ANGLE_BITS))) >> (62 - WORK_ANGLE_BITS);
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] val);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bit_w;
      v     = val;
      res   = '0;
      bit_w = 64'd1 << 62;
      for (int n = 0; n < 32; n++) begin
         if (bit_w > v) begin
            bit_w = bit_w >> 2;
         end
      end
      for (int n = 0; n < 32; n++) begin
         if (bit_w != 0) begin
            if (v >= res + bit_w) begin
               v   = v - (res + bit_w);
               res = (res >> 1) + bit_w;
            end else begin
               res = res >> 1;
            end
            bit_w = bit_w >> 2;
         end
      end
      return res;
   endfunction

   // inverse cordic gain in Q31
   function automatic logic [63:0] gain_q31();
      logic [63:0] v;
      v = 64'd1 << 62;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         v = v - long_div(v, (64'd1 << (2 * i)) + 64'd1);
      end
      return isqrt64(v);
   endfunction

   typedef logic [CORDIC_STAGES-1:0][ZW-1:0] atan_table_type;

   function automatic atan_table_type build_atan_table();
      atan_table_type t;
      logic [63:0]    a;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         a    = atan_step(i);
         t[i] = a[ZW-1:0];
      end
      return t;
   endfunction

   localparam atan_table_type ATAN_TABLE = build_atan_table();

   localparam logic [63:0] PI_F_RAW    = pi_at(ANGLE_FRACTION_BITS);
   localparam logic [63:0] HALF_PI_RAW = pi_at(WORK_ANGLE_BITS - 1);
   localparam logic [63:0] GAIN_RAW    = gain_q31();

   localparam logic signed [ANGLE_IN_W:0] PI_F     = $signed(PI_F_RAW[ANGLE_IN_W:0]);
   localparam logic signed [ANGLE_IN_W:0] TWO_PI_F = $signed(PI_F_RAW[ANGLE_IN_W-1:0] << 1);
   localparam logic signed [ZW-1:0]       HALF_PI_W = $signed(HALF_PI_RAW[ZW-1:0]);
   localparam logic [GAIN_W-1:0]          GAIN_K    = GAIN_RAW[GAIN_W-1:0];

   typedef struct packed {
      logic                           opcode;
      logic                           origin;
      logic signed [WORK_COORD_W-1:0] x;
      logic signed [WORK_COORD_W-1:0] y;
      logic signed [ZW-1:0]           z;
   } pcc_item_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x_out;
      logic signed [COORD_WIDTH-1:0] y_out;
      logic [RADIUS_W-1:0]           radius_out;
      logic signed [ANGLE_OUT_W-1:0] angle_out;
      logic                          saturated;
   } pcc_result_type;

endpackage

>>> sv/pcc_prep.sv
// ----------------------------------------------------------------------------
// pcc_prep
// Two-stage front end: angle wrap and scaling, then quadrant fold / left
// half-plane pre-rotation ahead of the cell chain.
// ----------------------------------------------------------------------------
module pcc_prep
   import pcc_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  logic                          in_valid,
   input  logic                          in_opcode,
   input  logic [RADIUS_W-1:0]           in_radius,
   input  logic signed [ANGLE_IN_W-1:0]  in_angle,
   input  logic signed [COORD_WIDTH-1:0] in_x,
   input  logic signed [COORD_WIDTH-1:0] in_y,
   output logic                          out_valid,
   output pcc_item_type                  out_item
);

   logic         wrap_valid_ff;
   pcc_item_type wrap_item_ff;
   pcc_item_type wrap_item_in;
   logic         fold_valid_ff;
   pcc_item_type fold_item_ff;
   pcc_item_type fold_item_in;

   logic signed [ANGLE_IN_W:0] angle_ext;
   logic signed [ANGLE_IN_W:0] angle_wrap;

   always_comb begin
      angle_ext = {in_angle[ANGLE_IN_W-1], in_angle};
      if (angle_ext > PI_F) begin
         angle_wrap = angle_ext - TWO_PI_F;
      end else if (angle_ext < -PI_F) begin
         angle_wrap = angle_ext + TWO_PI_F;
      end else begin
         angle_wrap = angle_ext;
      end

      wrap_item_in        = '0;
      wrap_item_in.opcode = in_opcode;
      if (in_opcode == 1'(OPCODE_TO_CARTESIAN)) begin
         wrap_item_in.x = $signed({{(WORK_COORD_W-RADIUS_W-COORD_GUARD){1'b0}}, in_radius,
                                   {COORD_GUARD{1'b0}}});
         wrap_item_in.z = ZW'(angle_wrap) <<< ANGLE_GUARD;
      end else begin
         wrap_item_in.origin = (in_x == '0) && (in_y == '0);
         wrap_item_in.x      = WORK_COORD_W'(in_x) <<< COORD_GUARD;
         wrap_item_in.y      = WORK_COORD_W'(in_y) <<< COORD_GUARD;
      end
   end

   always_comb begin
      fold_item_in = wrap_item_ff;
      if (wrap_item_ff.opcode == 1'(OPCODE_TO_CARTESIAN)) begin
         // start a quarter turn ahead when the angle is beyond +-pi/2
         if (wrap_item_ff.z > HALF_PI_W) begin
            fold_item_in.y = wrap_item_ff.x;
            fold_item_in.x = '0;
            fold_item_in.z = wrap_item_ff.z - HALF_PI_W;
         end else if (wrap_item_ff.z < -HALF_PI_W) begin
            fold_item_in.y = -wrap_item_ff.x;
            fold_item_in.x = '0;
            fold_item_in.z = wrap_item_ff.z + HALF_PI_W;
         end
      end else if (wrap_item_ff.x < 0) begin
         // left half plane: rotate into the right half first
         if (wrap_item_ff.y >= 0) begin
            fold_item_in.x = wrap_item_ff.y;
            fold_item_in.y = -wrap_item_ff.x;
            fold_item_in.z = HALF_PI_W;
         end else begin
            fold_item_in.x = -wrap_item_ff.y;
            fold_item_in.y = wrap_item_ff.x;
            fold_item_in.z = -HALF_PI_W;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_valid_ff <= 1'b0;
         fold_valid_ff <= 1'b0;
      end else if (enable) begin
         wrap_valid_ff <= in_valid;
         fold_valid_ff <= wrap_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         wrap_item_ff <= wrap_item_in;
         fold_item_ff <= fold_item_in;
      end
   end

   assign out_valid = fold_valid_ff;
   assign out_item  = fold_item_ff;

endmodule

>>> sv/pcc_cell.sv
// ----------------------------------------------------------------------------
// pcc_cell
// One cordic micro-rotation with its pipeline register.
// ----------------------------------------------------------------------------
module pcc_cell
   import pcc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic [STAGE_IDX_W-1:0] stage_idx,
   input  logic                   in_valid,
   input  pcc_item_type           in_item,
   output logic                   out_valid,
   output pcc_item_type           out_item
);

   logic         valid_ff;
   pcc_item_type item_ff;
   pcc_item_type item_in;

   logic signed [WORK_COORD_W-1:0] x_shift;
   logic signed [WORK_COORD_W-1:0] y_shift;
   logic signed [ZW-1:0]           step_angle;
   logic                           rot_pos;

   always_comb begin
      x_shift    = $signed(in_item.x) >>> stage_idx;
      y_shift    = $signed(in_item.y) >>> stage_idx;
      step_angle = $signed(ATAN_TABLE[stage_idx]);
      // rotation mode follows the residual angle, vectoring mode drives y to zero
      if (in_item.opcode == 1'(OPCODE_TO_POLAR)) begin
         rot_pos = in_item.y[WORK_COORD_W-1];
      end else begin
         rot_pos = !in_item.z[ZW-1];
      end

      item_in = in_item;
      if (rot_pos) begin
         item_in.x = in_item.x - y_shift;
         item_in.y = in_item.y + x_shift;
         item_in.z = in_item.z - step_angle;
      end else begin
         item_in.x = in_item.x + y_shift;
         item_in.y = in_item.y - x_shift;
         item_in.z = in_item.z + step_angle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

>>> sv/pcc_post.sv
// ----------------------------------------------------------------------------
// pcc_post
// Gain correction (magnitude, then multiply), guard-bit rounding, clamping
// and selection of the fields each opcode reports.
// ----------------------------------------------------------------------------
module pcc_post
   import pcc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           enable,
   input  logic           in_valid,
   input  pcc_item_type   in_item,
   output logic           out_valid,
   output pcc_result_type out_result
);

   localparam int SUM_W    = MAG_W + 2;
   localparam int DROP_W   = SUM_W - COORD_GUARD;
   localparam int ADROP_W  = ZW + 1 - ANGLE_GUARD;
   localparam int C_ROUND  = 2 ** (COORD_GUARD - 1);
   localparam int A_ROUND  = 2 ** (ANGLE_GUARD - 1);

   localparam logic signed [DROP_W-1:0]  CMAX_D = DROP_W'(COORD_MAX);
   localparam logic signed [DROP_W-1:0]  CMIN_D = DROP_W'(COORD_MIN);
   localparam logic signed [ADROP_W-1:0] PI_D   = ADROP_W'(PI_F);

   typedef struct packed {
      logic                 opcode;
      logic                 origin;
      logic                 neg_x;
      logic                 neg_y;
      logic [MAG_W-1:0]     mag_x;
      logic [MAG_W-1:0]     mag_y;
      logic signed [ZW-1:0] z;
   } mag_stage_type;

   typedef struct packed {
      logic                 opcode;
      logic                 origin;
      logic                 neg_x;
      logic                 neg_y;
      logic [PROD_W-1:0]    prod_x;
      logic [PROD_W-1:0]    prod_y;
      logic signed [ZW-1:0] z;
   } prod_stage_type;

   logic           mag_valid_ff;
   mag_stage_type  mag_ff;
   mag_stage_type  mag_in;
   logic           prod_valid_ff;
   prod_stage_type prod_ff;
   prod_stage_type prod_in;

   logic [WORK_COORD_W-1:0] neg_x_val;
   logic [WORK_COORD_W-1:0] neg_y_val;

   // signed magnitude back, then round off the guard bits
   function automatic logic signed [DROP_W-1:0] drop_guard(input logic [PROD_W-1:0] prod,
                                                           input logic neg);
      logic [MAG_W-1:0] r;
      logic [SUM_W-1:0] s;
      r = prod[PROD_W-1:GAIN_FRAC];
      if (neg) begin
         s = SUM_W'(C_ROUND) - SUM_W'(r);
      end else begin
         s = SUM_W'(r) + SUM_W'(C_ROUND);
      end
      return $signed(s[SUM_W-1:COORD_GUARD]);
   endfunction

   always_comb begin
      neg_x_val     = -in_item.x;
      neg_y_val     = -in_item.y;
      mag_in.opcode = in_item.opcode;
      mag_in.origin = in_item.origin;
      mag_in.neg_x  = in_item.x[WORK_COORD_W-1];
      mag_in.neg_y  = in_item.y[WORK_COORD_W-1];
      mag_in.mag_x  = in_item.x[WORK_COORD_W-1] ? neg_x_val[MAG_W-1:0] : in_item.x[MAG_W-1:0];
      mag_in.mag_y  = in_item.y[WORK_COORD_W-1] ? neg_y_val[MAG_W-1:0] : in_item.y[MAG_W-1:0];
      mag_in.z      = in_item.z;
   end

   always_comb begin
      prod_in.opcode = mag_ff.opcode;
      prod_in.origin = mag_ff.origin;
      prod_in.neg_x  = mag_ff.neg_x;
      prod_in.neg_y  = mag_ff.neg_y;
      prod_in.prod_x = PROD_W'(mag_ff.mag_x) * PROD_W'(GAIN_K);
      prod_in.prod_y = PROD_W'(mag_ff.mag_y) * PROD_W'(GAIN_K);
      prod_in.z      = mag_ff.z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else if (enable) begin
         mag_valid_ff  <= in_valid;
         prod_valid_ff <= mag_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         mag_ff  <= mag_in;
         prod_ff <= prod_in;
      end
   end

   logic signed [DROP_W-1:0]  dx;
   logic signed [DROP_W-1:0]  dy;
   logic signed [ZW:0]        z_round;
   logic signed [ADROP_W-1:0] da;
   logic signed [DROP_W-1:0]  cx;
   logic signed [DROP_W-1:0]  cy;
   logic signed [DROP_W-1:0]  cr;
   logic signed [ADROP_W-1:0] ca;
   logic                      sat_x;
   logic                      sat_y;
   logic                      sat_r;
   logic                      sat_a;

   always_comb begin
      dx      = drop_guard(prod_ff.prod_x, prod_ff.neg_x);
      dy      = drop_guard(prod_ff.prod_y, prod_ff.neg_y);
      z_round = {prod_ff.z[ZW-1], prod_ff.z} + (ZW+1)'(A_ROUND);
      da      = z_round[ZW:ANGLE_GUARD];

      sat_x = (dx > CMAX_D) || (dx < CMIN_D);
      cx    = (dx > CMAX_D) ? CMAX_D : ((dx < CMIN_D) ? CMIN_D : dx);
      sat_y = (dy > CMAX_D) || (dy < CMIN_D);
      cy    = (dy > CMAX_D) ? CMAX_D : ((dy < CMIN_D) ? CMIN_D : dy);
      sat_r = (dx > CMAX_D) || (dx < 0);
      cr    = (dx > CMAX_D) ? CMAX_D : ((dx < 0) ? '0 : dx);
      sat_a = (da > PI_D) || (da < -PI_D);
      ca    = (da > PI_D) ? PI_D : ((da < -PI_D) ? -PI_D : da);

      // fields an opcode does not use stay zero, as does the origin case
      out_result = '0;
      if (prod_ff.opcode == 1'(OPCODE_TO_CARTESIAN)) begin
         out_result.x_out     = cx[COORD_WIDTH-1:0];
         out_result.y_out     = cy[COORD_WIDTH-1:0];
         out_result.saturated = sat_x || sat_y;
      end else if (!prod_ff.origin) begin
         out_result.radius_out = cr[RADIUS_W-1:0];
         out_result.angle_out  = ca[ANGLE_OUT_W-1:0];
         out_result.saturated  = sat_r || sat_a;
      end
   end

   assign out_valid = prod_valid_ff;

endmodule

>>> sv/polar_cartesian_converter_core.sv
// ----------------------------------------------------------------------------
// polar_cartesian_converter_core
// Fixed-point polar <-> cartesian converter built on a chain of cordic cells.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one conversion per transaction; req_tuser is the opcode
//   (0 polar to cartesian, 1 cartesian to polar). rsp channel returns one result
//   per transaction, in order; rsp_tuser is the saturation flag.
//   A request passes from the accepting edge to rsp_tvalid through two front-end
//   stages (angle wrap, quadrant fold), one register per cordic cell
//   (CORDIC_STAGES of them), two gain stages (magnitude, multiply) and the
//   output register. Throughput is one transaction per cycle while the skid
//   slot is empty; the whole chain moves together on one shared enable.
//   When the receiver stalls, the output register holds its result and one
//   more result lands in a skid slot; req_tready drops only while that slot is
//   full, freezing the pipeline. No clearing pass: the block takes requests from
//   the first cycle after reset, which empties every valid bit.
// ----------------------------------------------------------------------------
module polar_cartesian_converter_core
   import pcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // radius_in, angle_in, x_in, y_in, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // x_out, y_out, radius_out, angle_out, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // saturated
   output logic                  rsp_tuser
);

   logic enable;

   logic         chain_valid [CORDIC_STAGES+1];
   pcc_item_type chain_item  [CORDIC_STAGES+1];

   logic           tail_valid;
   pcc_result_type tail_result;

   logic           out_valid_ff;
   pcc_result_type out_data_ff;
   logic           skid_valid_ff;
   pcc_result_type skid_data_ff;

   logic push;
   logic take;

   assign enable     = !skid_valid_ff;
   assign req_tready = enable;

   pcc_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (req_tvalid),
      .in_opcode (req_tuser),
      .in_radius (req_tdata[REQ_RADIUS_LSB +: RADIUS_W]),
      .in_angle  ($signed(req_tdata[REQ_ANGLE_LSB +: ANGLE_IN_W])),
      .in_x      ($signed(req_tdata[REQ_X_LSB +: COORD_WIDTH])),
      .in_y      ($signed(req_tdata[REQ_Y_LSB +: COORD_WIDTH])),
      .out_valid (chain_valid[0]),
      .out_item  (chain_item[0])
   );

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      pcc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .stage_idx (STAGE_IDX_W'(g)),
         .in_valid  (chain_valid[g]),
         .in_item   (chain_item[g]),
         .out_valid (chain_valid[g+1]),
         .out_item  (chain_item[g+1])
      );
   end

   pcc_post u_post (
      .clock      (clock),
      .reset      (reset),
      .enable     (enable),
      .in_valid   (chain_valid[CORDIC_STAGES]),
      .in_item    (chain_item[CORDIC_STAGES]),
      .out_valid  (tail_valid),
      .out_result (tail_result)
   );

   assign push = enable && tail_valid;
   assign take = out_valid_ff && rsp_tready;

   // output register plus one skid slot
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (take) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
         end
      end else if (!out_valid_ff) begin
         out_valid_ff <= push;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : tail_result;
      end else if (!out_valid_ff) begin
         out_data_ff <= tail_result;
      end else if (push) begin
         skid_data_ff <= tail_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_data_ff.saturated;
   assign rsp_tdata  = RSP_DATA_W'({out_data_ff.angle_out, out_data_ff.radius_out,
                                    out_data_ff.y_out, out_data_ff.x_out});

endmodule

>>> sv/pcc_checker.sv
// ----------------------------------------------------------------------------
// pcc_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
module pcc_checker
   import pcc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   localparam logic signed [ANGLE_OUT_W-1:0] PI_O = ANGLE_OUT_W'(PI_F);

   logic signed [ANGLE_OUT_W-1:0] rsp_angle;
   assign rsp_angle = $signed(rsp_tdata[RSP_ANGLE_LSB +: ANGLE_OUT_W]);

   // a stalled result holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // backpressure upstream only after the result side stalled
   a_ready_cause : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> $past(rsp_tvalid && !rsp_tready))
      else $error("req_tready low without a stalled result");

   // cartesian and polar fields never both carry data
   a_fields_exclusive : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_X_LSB +: COORD_WIDTH] == '0 &&
                      rsp_tdata[RSP_Y_LSB +: COORD_WIDTH] == '0) ||
                     (rsp_tdata[RSP_RADIUS_LSB +: RADIUS_W] == '0 &&
                      rsp_tdata[RSP_ANGLE_LSB +: ANGLE_OUT_W] == '0))
      else $error("both cartesian and polar fields nonzero");

   // angle stays within [-pi, pi]
   a_angle_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_angle <= PI_O) && (rsp_angle >= -PI_O))
      else $error("angle_out outside [-pi, pi]");

endmodule

bind polar_cartesian_converter_core pcc_checker u_pcc_checker (.*);

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for polar_cartesian_converter_core. Requests go in over
// the req stream in bursts, and each one is converted by a bit-exact cordic
// model kept here. The rsp stream stalls on its own pattern, and every result
// transaction is compared field by field with the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb
   import pcc_pkg::*;
();

   localparam int    RESET_CYCLES   = 6;
   localparam int    DRAIN_CYCLES   = 40;
   localparam int    IDLE_LIMIT     = 4000;
   localparam int    WORK_ANGLE     = ANGLE_FRACTION_BITS + ANGLE_GUARD;
   localparam longint COORD_HI      = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
   localparam longint COORD_LO      = -COORD_HI - 1;
   localparam longint RADIUS_HI     = COORD_HI;
   localparam logic [63:0] PI_TIMES_2_60 = 64'h3243F6A8885A308D;

   typedef struct {
      logic                  opcode;
      logic [RADIUS_W-1:0]   radius;
      logic [ANGLE_IN_W-1:0] angle;
      logic [COORD_WIDTH-1:0] x;
      logic [COORD_WIDTH-1:0] y;
   } conversion_type;

   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_LONG, STALL_LIGHT} stall_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   // rotation constants of the model
   longint         atan_rad[CORDIC_STAGES];
   longint unsigned inv_gain;
   longint         pi_f;
   longint         half_pi_work;
   longint         fold_edge;

   pcc_result_type pending_results[$];
   int             mismatches;
   int             burst_left;
   int             to_cartesian_sent;
   int             to_polar_sent;
   int             saturated_seen;

   polar_cartesian_converter_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint round_pi(int fb);
      return longint'((PI_TIMES_2_60 + (64'd1 << (59 - fb))) >> (60 - fb));
   endfunction

   // atan(2^-i) as a truncated series in Q62, inverse gain as the root of the product of 1/(1+4^-i)
   function automatic void build_rotation_constants();
      logic [63:0] q;
      logic [63:0] term;
      logic [63:0] v;
      logic [63:0] root;
      logic [63:0] trial;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         q = '0;
         if (i == 0) begin
            q = PI_TIMES_2_60;
         end else begin
            for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
               term = (64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1);
               q = (k % 2 == 1) ? q - term : q + term;
            end
         end
         atan_rad[i] = longint'((q + (64'd1 << (61 - WORK_ANGLE))) >> (62 - WORK_ANGLE));
      end
      v = 64'd1 << 62;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         v = v - v / ((64'd1 << (2 * i)) + 64'd1);
      end
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= v) begin
            root = trial;
         end
      end
      inv_gain     = root;
      pi_f         = round_pi(ANGLE_FRACTION_BITS);
      half_pi_work = round_pi(WORK_ANGLE - 1);
      fold_edge    = half_pi_work >>> ANGLE_GUARD;
   endfunction

   function automatic longint scale_by_gain(longint v);
      longint unsigned m;
      longint unsigned t;
      m = (v < 0) ? longint'(-v) : v;
      t = (m >> 16) * inv_gain + (((m & 64'hFFFF) * inv_gain) >> 16);
      return (v < 0) ? -longint'(t >> 15) : longint'(t >> 15);
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi, inout bit hit);
      if (v < lo) begin
         hit = 1'b1;
         return lo;
      end
      if (v > hi) begin
         hit = 1'b1;
         return hi;
      end
      return v;
   endfunction

   function automatic pcc_result_type cordic_convert(conversion_type item);
      pcc_result_type res;
      longint x, y, z, nx, ny, a, xi, yi;
      longint x_res, y_res, r_res, a_res;
      bit     hit;
      x_res = 0;
      y_res = 0;
      r_res = 0;
      a_res = 0;
      hit   = 1'b0;
      if (item.opcode == 1'(OPCODE_TO_CARTESIAN)) begin
         a = $signed(item.angle);
         if (a > pi_f) begin
            a = a - 2 * pi_f;
         end else if (a < -pi_f) begin
            a = a + 2 * pi_f;
         end
         z = a <<< ANGLE_GUARD;
         x = longint'(item.radius) <<< COORD_GUARD;
         y = 0;
         // start a quarter turn ahead when the angle lies past +/- pi/2
         if (z > half_pi_work) begin
            y = x;
            x = 0;
            z = z - half_pi_work;
         end else if (z < -half_pi_work) begin
            y = -x;
            x = 0;
            z = z + half_pi_work;
         end
         for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (z >= 0) begin
               nx = x - (y >>> i);
               ny = y + (x >>> i);
               z  = z - atan_rad[i];
            end else begin
               nx = x + (y >>> i);
               ny = y - (x >>> i);
               z  = z + atan_rad[i];
            end
            x = nx;
            y = ny;
         end
         x_res = clip((scale_by_gain(x) + 8) >>> COORD_GUARD, COORD_LO, COORD_HI, hit);
         y_res = clip((scale_by_gain(y) + 8) >>> COORD_GUARD, COORD_LO, COORD_HI, hit);
      end else begin
         xi = $signed(item.x);
         yi = $signed(item.y);
         if (xi != 0 || yi != 0) begin
            x = xi <<< COORD_GUARD;
            y = yi <<< COORD_GUARD;
            z = 0;
            // left half plane: turn by a quarter into the right half first
            if (x < 0) begin
               if (y >= 0) begin
                  nx = y;
                  ny = -x;
                  z  = half_pi_work;
               end else begin
                  nx = -y;
                  ny = x;
                  z  = -half_pi_work;
               end
               x = nx;
               y = ny;
            end
            for (int i = 0; i < CORDIC_STAGES; i++) begin
               if (y < 0) begin
                  nx = x - (y >>> i);
                  ny = y + (x >>> i);
                  z  = z - atan_rad[i];
               end else begin
                  nx = x + (y >>> i);
                  ny = y - (x >>> i);
                  z  = z + atan_rad[i];
               end
               x = nx;
               y = ny;
            end
            r_res = clip((scale_by_gain(x) + 8) >>> COORD_GUARD, 0, RADIUS_HI, hit);
            a_res = clip((z + 8) >>> ANGLE_GUARD, -pi_f, pi_f, hit);
         end
      end
      res.x_out      = x_res[COORD_WIDTH-1:0];
      res.y_out      = y_res[COORD_WIDTH-1:0];
      res.radius_out = r_res[RADIUS_W-1:0];
      res.angle_out  = a_res[ANGLE_OUT_W-1:0];
      res.saturated  = hit;
      return res;
   endfunction

   task automatic send_item(conversion_type item);
      logic [REQ_DATA_W-1:0] data;
      int                    gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 20);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      data = '0;
      data[REQ_RADIUS_LSB +: RADIUS_W]    = item.radius;
      data[REQ_ANGLE_LSB +: ANGLE_IN_W]   = item.angle;
      data[REQ_X_LSB +: COORD_WIDTH]      = item.x;
      data[REQ_Y_LSB +: COORD_WIDTH]      = item.y;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= item.opcode;
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(cordic_convert(item));
      if (item.opcode == 1'(OPCODE_TO_CARTESIAN)) begin
         to_cartesian_sent++;
      end else begin
         to_polar_sent++;
      end
      burst_left--;
   endtask

   function automatic conversion_type make_item(logic op, longint r, longint a, longint x,
                                                longint y);
      conversion_type item;
      item.opcode = op;
      item.radius = RADIUS_W'(r);
      item.angle  = ANGLE_IN_W'(a);
      item.x      = COORD_WIDTH'(x);
      item.y      = COORD_WIDTH'(y);
      return item;
   endfunction

   function automatic conversion_type random_item(bit near_edges);
      conversion_type item;
      longint         base;
      item.opcode = 1'($urandom_range(0, 1));
      item.radius = RADIUS_W'($urandom());
      item.angle  = ANGLE_IN_W'($urandom());
      item.x      = COORD_WIDTH'($urandom());
      item.y      = COORD_WIDTH'($urandom());
      if (near_edges) begin
         if (item.opcode == 1'(OPCODE_TO_CARTESIAN)) begin
            case ($urandom_range(0, 3))
               0: item.radius = RADIUS_W'($urandom_range(0, 255));
               1: item.radius = RADIUS_W'(RADIUS_HI - $urandom_range(0, 255));
               default: ;
            endcase
            case ($urandom_range(0, 4))
               0: base = pi_f;
               1: base = -pi_f;
               2: base = fold_edge;
               3: base = -fold_edge;
               default: base = 0;
            endcase
            item.angle = ANGLE_IN_W'(base + int'($urandom_range(0, 32)) - 16);
         end else begin
            case ($urandom_range(0, 4))
               0: begin
                  item.x = COORD_WIDTH'(int'($urandom_range(0, 64)) - 32);
                  item.y = COORD_WIDTH'(int'($urandom_range(0, 64)) - 32);
               end
               1: item.x = '0;
               2: item.y = '0;
               3: begin
                  item.x = COORD_WIDTH'($urandom_range(0, 1) ? COORD_LO + $urandom_range(0, 63)
                                                             : COORD_HI - $urandom_range(0, 63));
                  item.y = COORD_WIDTH'($urandom_range(0, 1) ? COORD_LO + $urandom_range(0, 63)
                                                             : COORD_HI - $urandom_range(0, 63));
               end
               default: ;
            endcase
         end
      end
      return item;
   endfunction

   // radius extremes, angle wrap at +/- pi, the quadrant fold at +/- pi/2
   task automatic test_cartesian_edges();
      logic op;
      op = 1'(OPCODE_TO_CARTESIAN);
      send_item(make_item(op, 0, 0, -1, -1));
      send_item(make_item(op, RADIUS_HI, 0, 0, 0));
      send_item(make_item(op, RADIUS_HI, pi_f, 0, 0));
      send_item(make_item(op, RADIUS_HI, -pi_f, 0, 0));
      send_item(make_item(op, RADIUS_HI, pi_f + 1, 0, 0));
      send_item(make_item(op, RADIUS_HI, -pi_f - 1, 0, 0));
      send_item(make_item(op, 1000, COORD_HI, 0, 0));
      send_item(make_item(op, 1000, COORD_LO, 0, 0));
      send_item(make_item(op, 5000, fold_edge, 0, 0));
      send_item(make_item(op, 5000, fold_edge + 1, 0, 0));
      send_item(make_item(op, 5000, -fold_edge, 0, 0));
      send_item(make_item(op, 5000, -fold_edge - 1, 0, 0));
   endtask

   // origin, the axes, each half plane and the saturating corners
   task automatic test_polar_edges();
      logic op;
      op = 1'(OPCODE_TO_POLAR);
      send_item(make_item(op, RADIUS_HI, -1, 0, 0));
      send_item(make_item(op, 0, 0, 0, 256));
      send_item(make_item(op, 0, 0, 0, -256));
      send_item(make_item(op, 0, 0, -256, 0));
      send_item(make_item(op, 0, 0, -256, -1));
      send_item(make_item(op, 0, 0, COORD_LO, COORD_LO));
      send_item(make_item(op, 0, 0, COORD_HI, COORD_HI));
      send_item(make_item(op, 0, 0, COORD_LO, 0));
      send_item(make_item(op, 0, 0, COORD_HI, COORD_LO));
      send_item(make_item(op, 0, 0, 1, 0));
      send_item(make_item(op, 0, 0, -1, -1));
      send_item(make_item(op, 0, 0, 0, COORD_LO));
   endtask

   task automatic test_random_full(int count);
      repeat (count) send_item(random_item(1'b0));
   endtask

   task automatic test_random_edges(int count);
      repeat (count) send_item(random_item(1'b1));
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 'h%0h, actual 'h%0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      pcc_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result transaction with nothing pending, data 'h%0h", rsp_tdata);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            check_field("x_out", {want.x_out}, {rsp_tdata[RSP_X_LSB +: COORD_WIDTH]});
            check_field("y_out", {want.y_out}, {rsp_tdata[RSP_Y_LSB +: COORD_WIDTH]});
            check_field("radius_out", {want.radius_out},
                        {rsp_tdata[RSP_RADIUS_LSB +: RADIUS_W]});
            check_field("angle_out", {want.angle_out},
                        {rsp_tdata[RSP_ANGLE_LSB +: ANGLE_OUT_W]});
            check_field("saturated", {want.saturated}, {rsp_tuser});
         end
         if (rsp_tuser) begin
            saturated_seen++;
         end
      end
   end

   // receiver back-pressure, switching between patterns after phases of random length
   initial begin : rsp_stall_pattern
      stall_mode_type mode;
      int             hold;
      int             phase_left;
      rsp_tready = 1'b0;
      mode       = STALL_NONE;
      hold       = 0;
      phase_left = 0;
      forever begin
         @(negedge clock);
         if (phase_left == 0) begin
            mode       = stall_mode_type'($urandom_range(0, 3));
            phase_left = $urandom_range(50, 300);
         end
         phase_left--;
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               STALL_NONE:   rsp_tready <= 1'b1;
               STALL_RANDOM: rsp_tready <= 1'($urandom_range(0, 1));
               STALL_LONG: begin
                  hold = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 30) : 0;
                  rsp_tready <= (hold == 0);
               end
               default:      rsp_tready <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("polar_cartesian_converter_core test failed");
      $finish;
   end

   initial begin
      reset             = 1'b1;
      req_tvalid        = 1'b0;
      req_tdata         = '0;
      req_tuser         = 1'b0;
      mismatches        = 0;
      burst_left        = 0;
      to_cartesian_sent = 0;
      to_polar_sent     = 0;
      saturated_seen    = 0;
      build_rotation_constants();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_cartesian_edges();
      test_polar_edges();
      test_random_full(450);
      test_random_edges(250);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("converted %0d polar-to-cartesian and %0d cartesian-to-polar transactions,",
               to_cartesian_sent, to_polar_sent);
      $display("%0d results came back saturated, %0d mismatches", saturated_seen, mismatches);
      if (mismatches == 0) begin
         $display("polar_cartesian_converter_core test passed");
      end else begin
         $display("polar_cartesian_converter_core test failed");
      end
      $finish;
   end

endmodule
